@@ sv/mesh_surface_point_sampler_assert.svh @@
// Assertion macros for the mesh surface point sampler.
`ifndef MESH_SURFACE_POINT_SAMPLER_ASSERT_SVH
`define MESH_SURFACE_POINT_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define MSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MSPS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define MSPS_ASSERT(lbl, prop, msg)
`define MSPS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ sv/msps_pkg.sv @@
// Shared types, constants and helpers of the mesh surface point sampler.
package msps_pkg;

  localparam int unsigned COORD_W          = 32;
  localparam int unsigned MAX_FACE_LEVELS  = 4;
  localparam int unsigned MAX_EDGE_SAMPLES = 64;

  localparam int unsigned NUM_CORNERS = 3;
  localparam int unsigned TRI_COORDS  = 3 * NUM_CORNERS;
  localparam int unsigned ROW_COORDS  = TRI_COORDS + 3;
  localparam int unsigned ROW_W       = ROW_COORDS * COORD_W;
  localparam int unsigned LVL_W       = (MAX_FACE_LEVELS > 1) ? $clog2(MAX_FACE_LEVELS) : 1;

  localparam int unsigned ES_W     = 7;
  localparam int unsigned FL_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = ES_W;
  localparam int unsigned CNT_W    = 7;

  // divider: numerator covers step * (b - a) and the three-corner sum
  localparam int unsigned NUM_W   = COORD_W + 8;
  localparam int unsigned DEN_W   = 7;
  localparam int unsigned NUM_LANES = 3;

  localparam int unsigned IN_DATA_W  = TRI_COORDS * COORD_W;
  localparam int unsigned OUT_DATA_W = 3 * COORD_W;
  localparam int unsigned CMD_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_VERTEX = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_FACE   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_SUBSAMPLES = 2'd0,
    CFG_FACE_LEVELS     = 2'd1,
    CFG_UNUSED_2        = 2'd2,
    CFG_UNUSED_3        = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FSTART,
    ST_EMUL,
    ST_ESTART,
    ST_DIV,
    ST_EMIT,
    ST_READ,
    ST_EXPAND
  } state_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // number of samples of a face subdivided to lv levels
  function automatic logic [CNT_W-1:0] face_count(input logic [FL_W-1:0] lv);
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] pw;
    cnt = '0;
    pw  = CNT_W'(1);
    for (int k = 0; k < int'(MAX_FACE_LEVELS); k++) begin
      if (k < int'(lv)) begin
        cnt = cnt + pw;
        pw  = CNT_W'(pw * CNT_W'(3));
      end
    end
    return cnt;
  endfunction

endpackage

@@ sv/msps_ram.sv @@
// Generic single-port-write, registered-read RAM.
module msps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/msps_div.sv @@
// Three-lane bit-serial signed divider with round-to-nearest, ties away from zero.
module msps_div
  import msps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  input  num_t      num_i [NUM_LANES],
  output div_stat_t stat_o,
  output num_t      quo_o [NUM_LANES]
);

  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned CNT_DW = $clog2(NUM_W);
  localparam logic [CNT_DW-1:0] CNT_LAST = CNT_DW'(NUM_W - 1);

  logic              busy_q, done_q;
  logic [CNT_DW-1:0] cnt_q;
  logic [DEN_W-1:0]  den_q;
  logic              neg_q [NUM_LANES];
  logic [NUM_W-1:0]  mag_q [NUM_LANES];
  logic [REM_W-1:0]  rem_q [NUM_LANES];
  logic [REM_W-1:0]  rem_d [NUM_LANES];
  logic              bit_d [NUM_LANES];
  logic [NUM_W-1:0]  mag_d [NUM_LANES];

  always_comb begin
    for (int l = 0; l < int'(NUM_LANES); l++) begin
      logic [REM_W-1:0] sh;
      logic [NUM_W-1:0] a;
      sh = {rem_q[l][REM_W-2:0], mag_q[l][NUM_W-1]};
      if (sh >= {1'b0, den_q}) begin
        rem_d[l] = sh - {1'b0, den_q};
        bit_d[l] = 1'b1;
      end else begin
        rem_d[l] = sh;
        bit_d[l] = 1'b0;
      end
      a = num_i[l][NUM_W-1] ? NUM_W'(-num_i[l]) : NUM_W'(num_i[l]);
      mag_d[l] = a + NUM_W'(req_i.den >> 1);
      quo_o[l] = neg_q[l] ? num_t'(-mag_q[l]) : num_t'(mag_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_DW'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      for (int l = 0; l < int'(NUM_LANES); l++) begin
        neg_q[l] <= num_i[l][NUM_W-1];
        mag_q[l] <= mag_d[l];
        rem_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < int'(NUM_LANES); l++) begin
        rem_q[l] <= rem_d[l];
        mag_q[l] <= {mag_q[l][NUM_W-2:0], bit_d[l]};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ sv/mesh_surface_point_sampler.sv @@
// Top level of the mesh surface point sampler: control, stack memory and output register.
//
// A vertex transaction goes straight to the emit state and yields its first corner. Every edge point
// and every face centroid goes through the bit-serial divider, which raises its done flag once
// all NUM_W (40) quotient bits are in. An edge point also passes the multiply and start states,
// and a face centroid the start state; each further face triangle first passes the stack read and
// expand states. Triangles on the current subdivision path sit in a four-row stack memory, one
// row per level holding the three corners and their centroid. The input side is ready only
// between transactions; the output register lets a new item start while the last sample
// still waits.
module mesh_surface_point_sampler
  import msps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // ax, ay, az, bx, by, bz, cx, cy, cz
  input  logic [CMD_W-1:0]     s_axis_tuser,   // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // sample_x, sample_y, sample_z
  output logic                 m_axis_tlast,   // last
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic [ES_W-1:0]  es_q;
  logic [FL_W-1:0]  fl_q;
  logic [ES_W-1:0]  n_sat;
  logic [FL_W-1:0]  lv_sat;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic [ES_W-1:0]  step_q, step_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [1:0]       child_q [MAX_FACE_LEVELS];
  logic [1:0]       child_d [MAX_FACE_LEVELS];
  coord_t tri_q [TRI_COORDS];
  coord_t tri_d [TRI_COORDS];
  coord_t res_q [3];
  coord_t res_d [3];
  num_t   prod_q [NUM_LANES];
  num_t   div_num [NUM_LANES];
  num_t   div_quo [NUM_LANES];
  div_req_t  div_req;
  div_stat_t div_stat;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;
  logic              m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic              m_last_q;
  logic              out_load;
  logic              in_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign n_sat  = (es_q > ES_W'(MAX_EDGE_SAMPLES)) ? ES_W'(MAX_EDGE_SAMPLES) : es_q;
  assign lv_sat = (fl_q > FL_W'(MAX_FACE_LEVELS)) ? FL_W'(MAX_FACE_LEVELS) : fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q <= '0;
      fl_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EDGE_SUBSAMPLES: es_q <= cfg_data_i;
        CFG_FACE_LEVELS:     fl_q <= cfg_data_i[FL_W-1:0];
        default: ;
      endcase
    end
  end

  msps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  msps_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_FACE_LEVELS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (level_q),
    .wdata_i (ram_wdata),
    .raddr_i (level_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int k = 0; k < int'(TRI_COORDS); k++) begin
      ram_wdata[k*COORD_W +: COORD_W] = tri_q[k];
    end
    for (int j = 0; j < 3; j++) begin
      ram_wdata[(TRI_COORDS+j)*COORD_W +: COORD_W] = div_quo[j][COORD_W-1:0];
    end
  end

  always_comb begin
    div_req.den = (cmd_q == CMD_FACE) ? DEN_W'(3) : DEN_W'(n_sat) + DEN_W'(1);
    for (int j = 0; j < 3; j++) begin
      if (cmd_q == CMD_FACE) begin
        div_num[j] = num_t'(tri_q[j]) + num_t'(tri_q[3+j]) + num_t'(tri_q[6+j]);
      end else begin
        div_num[j] = prod_q[j];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    remain_d = remain_q;
    step_d   = step_q;
    level_d  = level_q;
    child_d  = child_q;
    tri_d    = tri_q;
    res_d    = res_q;
    div_req.start = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d = cmd_e'(s_axis_tuser);
          for (int k = 0; k < int'(TRI_COORDS); k++) begin
            tri_d[k] = s_axis_tdata[k*COORD_W +: COORD_W];
          end
          for (int l = 0; l < int'(MAX_FACE_LEVELS); l++) begin
            child_d[l] = '0;
          end
          level_d = '0;
          step_d  = ES_W'(1);
          unique case (cmd_e'(s_axis_tuser))
            CMD_VERTEX: begin
              remain_d = CNT_W'(1);
              for (int j = 0; j < 3; j++) begin
                res_d[j] = s_axis_tdata[j*COORD_W +: COORD_W];
              end
              state_d = ST_EMIT;
            end
            CMD_EDGE: begin
              remain_d = CNT_W'(n_sat);
              if (n_sat != '0) state_d = ST_EMUL;
            end
            CMD_FACE: begin
              remain_d = face_count(lv_sat);
              if (lv_sat != '0) state_d = ST_FSTART;
            end
            default: remain_d = '0;
          endcase
        end
      end
      ST_FSTART: begin
        div_req.start = 1'b1;
        state_d = ST_DIV;
      end
      ST_EMUL: state_d = ST_ESTART;
      ST_ESTART: begin
        div_req.start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          for (int j = 0; j < 3; j++) begin
            if (cmd_q == CMD_FACE) begin
              res_d[j] = div_quo[j][COORD_W-1:0];
            end else begin
              res_d[j] = COORD_W'(num_t'(tri_q[j]) + div_quo[j]);
            end
          end
          ram_we  = (cmd_q == CMD_FACE);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          remain_d = remain_q - CNT_W'(1);
          step_d   = step_q + ES_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else if (cmd_q == CMD_EDGE) begin
            state_d = ST_EMUL;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EXPAND;
      ST_EXPAND: begin
        logic [1:0] ch, cq;
        ch = child_q[level_q];
        cq = (ch == 2'd2) ? 2'd0 : ch + 2'd1;
        if ((FL_W'(level_q) + FL_W'(1) < lv_sat) && (ch != 2'd3)) begin
          for (int j = 0; j < 3; j++) begin
            tri_d[j]   = ram_rdata[(int'(ch)*3+j)*COORD_W +: COORD_W];
            tri_d[3+j] = ram_rdata[(int'(cq)*3+j)*COORD_W +: COORD_W];
            tri_d[6+j] = ram_rdata[(TRI_COORDS+j)*COORD_W +: COORD_W];
          end
          child_d[level_q] = ch + 2'd1;
          level_d = level_q + LVL_W'(1);
          child_d[level_q + LVL_W'(1)] = '0;
          state_d = ST_FSTART;
        end else if (level_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          level_d = level_q - LVL_W'(1);
          state_d = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cmd_q    <= CMD_NONE;
      remain_q <= '0;
      step_q   <= '0;
      level_q  <= '0;
      for (int l = 0; l < int'(MAX_FACE_LEVELS); l++) begin
        child_q[l] <= '0;
      end
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      remain_q <= remain_d;
      step_q   <= step_d;
      level_q  <= level_d;
      child_q  <= child_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q <= tri_d;
    res_q <= res_d;
    if (state_q == ST_EMUL) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= num_t'($signed({1'b0, step_q})) *
                     (num_t'(tri_q[3+j]) - num_t'(tri_q[j]));
      end
    end
    if (out_load) begin
      m_data_q <= {res_q[2], res_q[1], res_q[0]};
      m_last_q <= (remain_q == CNT_W'(1));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`include "mesh_surface_point_sampler_assert.svh"

  `MSPS_ASSERT(a_idle_no_pending, (state_q == ST_IDLE) |-> (remain_q == '0), "idle with samples pending")
  `MSPS_ASSERT(a_idle_div_quiet, (state_q == ST_IDLE) |-> !div_stat.busy, "divider busy while idle")
  `MSPS_ASSERT_NEVER(a_no_overwrite, out_load && m_valid_q && !m_axis_tready, "output overwritten")

endmodule
